@@ rtl/assert_macros.svh @@
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ rtl/qrk_pkg.sv @@
// Package: shared types, constants and the quaternion product term table.
package qrk_pkg;

  localparam int RATE_W     = 32;
  localparam int STEP_W     = 24;
  localparam int AVEC_W     = 56;
  localparam int HALF_SHIFT = 41;
  localparam int DIG_W      = 14;
  localparam logic [STEP_W-1:0] STEP_RESET = 24'd167772;

  typedef struct packed {
    logic start;
  } qrk_div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } qrk_div_sts_t;

  typedef struct packed {
    logic [1:0] pidx;
    logic [1:0] aidx;
    logic       neg;
  } qrk_term_t;

  // One product of p (x) (0, a): which p, which a, and whether it is subtracted.
  function automatic qrk_term_t qrk_term(input logic [1:0] comp, input logic [1:0] term);
    qrk_term_t e;
    e = '0;
    unique case ({comp, term})
      4'b0000: e = '{pidx: 2'd1, aidx: 2'd0, neg: 1'b1};
      4'b0001: e = '{pidx: 2'd2, aidx: 2'd1, neg: 1'b1};
      4'b0010: e = '{pidx: 2'd3, aidx: 2'd2, neg: 1'b1};
      4'b0100: e = '{pidx: 2'd0, aidx: 2'd0, neg: 1'b0};
      4'b0101: e = '{pidx: 2'd2, aidx: 2'd2, neg: 1'b0};
      4'b0110: e = '{pidx: 2'd3, aidx: 2'd1, neg: 1'b1};
      4'b1000: e = '{pidx: 2'd0, aidx: 2'd1, neg: 1'b0};
      4'b1001: e = '{pidx: 2'd1, aidx: 2'd2, neg: 1'b1};
      4'b1010: e = '{pidx: 2'd3, aidx: 2'd0, neg: 1'b0};
      4'b1100: e = '{pidx: 2'd0, aidx: 2'd2, neg: 1'b0};
      4'b1101: e = '{pidx: 2'd2, aidx: 2'd0, neg: 1'b1};
      4'b1110: e = '{pidx: 2'd1, aidx: 2'd1, neg: 1'b0};
      default: e = '0;
    endcase
    return e;
  endfunction

endpackage

@@ rtl/qrk_if.sv @@
// Channel interfaces: rate input beats and quaternion result beats.
interface qrk_rate_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] rate_x;
  logic signed [31:0] rate_y;
  logic signed [31:0] rate_z;
  modport source (output valid, output rate_x, output rate_y, output rate_z, input ready);
  modport sink (input valid, input rate_x, input rate_y, input rate_z, output ready);
endinterface

interface qrk_quat_if #(parameter int QUAT_WIDTH = 32);
  logic                         valid;
  logic                         ready;
  logic signed [QUAT_WIDTH-1:0] quat_w;
  logic signed [QUAT_WIDTH-1:0] quat_x;
  logic signed [QUAT_WIDTH-1:0] quat_y;
  logic signed [QUAT_WIDTH-1:0] quat_z;
  modport source (output valid, output quat_w, output quat_x, output quat_y, output quat_z,
                  input ready);
  modport sink (input valid, input quat_w, input quat_x, input quat_y, input quat_z,
                output ready);
endinterface

@@ rtl/qrk_div.sv @@
// Restoring divider, one quotient bit per cycle.
module qrk_div
  import qrk_pkg::*;
#(
  parameter int NUM_W = 64,
  parameter int DEN_W = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  qrk_div_ctl_t       ctl,
  input  logic [NUM_W-1:0]   num,
  input  logic [DEN_W-1:0]   den,
  output qrk_div_sts_t       sts,
  output logic [NUM_W-1:0]   quo
);

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] num_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W:0]   trial;
  logic             ge;

  assign trial = {rem_r, num_r[NUM_W-1]};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[NUM_W-2:0], 1'b0};
      quo_r <= {quo_r[NUM_W-2:0], ge};
      rem_r <= ge ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quo      = quo_r;

endmodule

@@ rtl/quaternion_rk4_attitude_step_unit.sv @@
// Top level: RK4 quaternion attitude step with renormalization.
//
//  channel  dir  handshake          payload
//  in_if    in   valid/ready        rate_x, rate_y, rate_z (Q16.16)
//  out_if   out  valid/ready        quat_w..quat_z (Q2.30 at default width)
//  cfg_*    in   cfg_wr_en          cfg_wr_data = step_time (Q0.24)
//
// A beat's time from the accept edge to the result edge is set by the shared digit
// multiplier and the bit-serial divider; a zero norm skips the root and the divides.
// in_if.ready is high only while idle with no result pending; a result holds on
// out_if until taken. Reset sets identity orientation.
`include "assert_macros.svh"

module quaternion_rk4_attitude_step_unit
  import qrk_pkg::*;
#(
  parameter int QUAT_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [STEP_W-1:0]    cfg_wr_data,
  qrk_rate_if.sink             in_if,
  qrk_quat_if.source           out_if
);

  localparam int W    = QUAT_WIDTH;
  localparam int F    = W - 2;
  localparam int BW   = (W > AVEC_W) ? W : AVEC_W;
  localparam int ND   = (BW + DIG_W - 1) / DIG_W;
  localparam int BPW  = ND * DIG_W;
  localparam int AW   = W + BPW + 3;
  localparam int NW   = 2 * W;
  localparam int DGW  = $clog2(ND);
  localparam int SQW  = $clog2(W);
  localparam int DK   = (W % 2 == 0) ? W + 1 : W + 2;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_AMUL  = 4'd1;
  localparam logic [3:0] ST_MAC   = 4'd2;
  localparam logic [3:0] ST_RND   = 4'd3;
  localparam logic [3:0] ST_STG   = 4'd4;
  localparam logic [3:0] ST_SUMGO = 4'd5;
  localparam logic [3:0] ST_SUMWT = 4'd6;
  localparam logic [3:0] ST_SQCHK = 4'd7;
  localparam logic [3:0] ST_SQRT  = 4'd8;
  localparam logic [3:0] ST_NRMGO = 4'd9;
  localparam logic [3:0] ST_NRMWT = 4'd10;
  localparam logic [3:0] ST_OUT   = 4'd11;

  localparam logic signed [AW-1:0] QMAX_A   = {{(AW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [AW-1:0] RND_HALF = AW'(1) << (HALF_SHIFT - 1);
  localparam logic [NW-1:0]        SQ_TOP   = NW'(1) << (NW - 2);
  localparam logic [W+2:0]         SUM_THREE = (W+3)'(3);
  localparam logic [DK:0]          DIV3_FULL = ({1'b1, {DK{1'b0}}} + (DK+1)'(1)) / (DK+1)'(3);
  localparam logic [BPW-1:0]       DIV3_M    = BPW'(DIV3_FULL);

  function automatic logic signed [W-1:0] sat(input logic signed [AW-1:0] v);
    logic signed [AW-1:0] r;
    r = v;
    if (v > QMAX_A) r = QMAX_A;
    else if (v < -QMAX_A) r = -QMAX_A;
    return r[W-1:0];
  endfunction

  logic [3:0]               state_r;
  logic [STEP_W-1:0]        step_r;
  logic signed [RATE_W-1:0] rate_r [3];
  logic signed [AVEC_W-1:0] a_r    [3];
  logic signed [W-1:0]      q_r    [4];
  logic signed [W-1:0]      p_r    [4];
  logic signed [W-1:0]      d_r    [4];
  logic signed [W-1:0]      qn_r   [4];
  logic signed [W+2:0]      wsum_r [4];
  logic signed [AW-1:0]     acc_r;
  logic [1:0]               comp_r;
  logic [1:0]               term_r;
  logic [1:0]               stage_r;
  logic [DGW-1:0]           dig_r;
  logic                     sq_r;
  logic                     dv_r;
  logic [NW-1:0]            sq_n_r;
  logic [NW-1:0]            sq_res_r;
  logic [NW-1:0]            sq_bit_r;
  logic [SQW-1:0]           sq_cnt_r;
  logic [W-1:0]             root;

  qrk_div_ctl_t      div_ctl;
  qrk_div_sts_t      div_sts;
  logic [NW-1:0]     div_num;
  logic [W-1:0]      div_den;
  logic [NW-1:0]     div_quo;

  qrk_term_t                tsel;
  logic signed [W+1:0]      mac_a;
  logic signed [AVEC_W-1:0] a_sel;
  logic [BPW-1:0]           mac_b;
  logic                     mac_neg;
  logic [DIG_W-1:0]         digit;
  logic signed [W+DIG_W+2:0] prod;
  logic signed [AW-1:0]     prod_sh;
  logic signed [AW-1:0]     acc_add;
  logic                     mac_last;
  logic signed [AW-1:0]     rnd_v;
  logic signed [W-1:0]      d_new;
  logic signed [AW-1:0]     quo_s;
  logic signed [AW-1:0]     quo6;
  logic [W+2:0]             wsum_mag;
  logic [W:0]               sum_y;
  logic [W-1:0]             qn_mag;
  logic [NW-1:0]            sq_t;

  // digit-serial multiply-accumulate operand select
  always_comb begin
    tsel = qrk_term(comp_r, term_r);
    a_sel = a_r[tsel.aidx];
    if (sq_r) begin
      mac_a   = (W+2)'(qn_r[term_r]);
      mac_b   = BPW'($unsigned(qn_r[term_r] < 0 ? -qn_r[term_r] : qn_r[term_r]));
      mac_neg = qn_r[term_r] < 0;
    end else if (dv_r) begin
      mac_a   = $signed({1'b0, sum_y});
      mac_b   = DIV3_M;
      mac_neg = 1'b0;
    end else begin
      mac_a   = (W+2)'(p_r[tsel.pidx]);
      mac_b   = BPW'($unsigned(a_sel < 0 ? -a_sel : a_sel));
      mac_neg = tsel.neg ^ (a_sel < 0);
    end
  end

  assign digit    = mac_b[dig_r*DIG_W +: DIG_W];
  assign prod     = mac_a * $signed({1'b0, digit});
  assign prod_sh  = AW'(prod) <<< (dig_r * DIG_W);
  assign acc_add  = mac_neg ? -prod_sh : prod_sh;
  assign mac_last = (dig_r == DGW'(ND - 1)) &&
                    (term_r == (sq_r ? 2'd3 : (dv_r ? 2'd0 : 2'd2)));

  assign rnd_v = (acc_r + RND_HALF) >>> HALF_SHIFT;
  assign d_new = sat(rnd_v);

  assign quo_s    = AW'(div_quo);
  assign quo6     = acc_r >>> DK;
  assign wsum_mag = $unsigned(wsum_r[comp_r] < 0 ? -wsum_r[comp_r] : wsum_r[comp_r]);
  assign sum_y    = (W+1)'((wsum_mag + SUM_THREE) >> 1);
  assign qn_mag   = W'($unsigned(qn_r[comp_r] < 0 ? -qn_r[comp_r] : qn_r[comp_r]));
  assign sq_t     = sq_res_r + sq_bit_r;
  assign root     = sq_res_r[W-1:0];

  assign div_ctl.start = (state_r == ST_NRMGO);
  assign div_num       = (NW'(qn_mag) << F) + NW'(root >> 1);
  assign div_den       = root;

  qrk_div #(.NUM_W(NW), .DEN_W(W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (div_ctl),
    .num   (div_num),
    .den   (div_den),
    .sts   (div_sts),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_RESET;
    end else if (cfg_wr_en) begin
      step_r <= cfg_wr_data;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      q_r[0]  <= W'(1) << F;
      q_r[1]  <= '0;
      q_r[2]  <= '0;
      q_r[3]  <= '0;
      comp_r  <= '0;
      term_r  <= '0;
      stage_r <= '0;
      dig_r   <= '0;
      sq_r    <= 1'b0;
      dv_r    <= 1'b0;
      sq_cnt_r <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_if.valid) begin
            rate_r[0] <= in_if.rate_x;
            rate_r[1] <= in_if.rate_y;
            rate_r[2] <= in_if.rate_z;
            comp_r    <= '0;
            state_r   <= ST_AMUL;
          end
        end
        ST_AMUL: begin
          a_r[comp_r] <= AVEC_W'(rate_r[comp_r]) * AVEC_W'($signed({1'b0, step_r}));
          if (comp_r == 2'd2) begin
            p_r     <= q_r;
            comp_r  <= '0;
            term_r  <= '0;
            dig_r   <= '0;
            stage_r <= '0;
            sq_r    <= 1'b0;
            dv_r    <= 1'b0;
            acc_r   <= '0;
            state_r <= ST_MAC;
          end else begin
            comp_r <= comp_r + 1'b1;
          end
        end
        ST_MAC: begin
          acc_r <= acc_r + acc_add;
          if (mac_last) begin
            dig_r   <= '0;
            term_r  <= '0;
            state_r <= sq_r ? ST_SQCHK : (dv_r ? ST_SUMWT : ST_RND);
          end else if (dig_r == DGW'(ND - 1)) begin
            dig_r  <= '0;
            term_r <= term_r + 1'b1;
          end else begin
            dig_r <= dig_r + 1'b1;
          end
        end
        ST_RND: begin
          d_r[comp_r] <= d_new;
          if (stage_r == 2'd0) begin
            wsum_r[comp_r] <= (W+3)'(d_new);
          end else if (stage_r == 2'd3) begin
            wsum_r[comp_r] <= wsum_r[comp_r] + (W+3)'(d_new);
          end else begin
            wsum_r[comp_r] <= wsum_r[comp_r] + ((W+3)'(d_new) <<< 1);
          end
          acc_r <= '0;
          if (comp_r != 2'd3) begin
            comp_r  <= comp_r + 1'b1;
            state_r <= ST_MAC;
          end else begin
            comp_r  <= '0;
            state_r <= (stage_r == 2'd3) ? ST_SUMGO : ST_STG;
          end
        end
        ST_STG: begin
          for (int i = 0; i < 4; i++) begin
            if (stage_r == 2'd2) begin
              p_r[i] <= sat(AW'(q_r[i]) + AW'(d_r[i]));
            end else begin
              p_r[i] <= sat(AW'(q_r[i]) + ((AW'(d_r[i]) + AW'(1)) >>> 1));
            end
          end
          stage_r <= stage_r + 1'b1;
          state_r <= ST_MAC;
        end
        ST_SUMGO: begin
          acc_r   <= '0;
          dig_r   <= '0;
          term_r  <= '0;
          dv_r    <= 1'b1;
          state_r <= ST_MAC;
        end
        ST_SUMWT: begin
          qn_r[comp_r] <= wsum_r[comp_r] < 0 ? sat(AW'(q_r[comp_r]) - quo6)
                                             : sat(AW'(q_r[comp_r]) + quo6);
          if (comp_r == 2'd3) begin
            comp_r  <= '0;
            term_r  <= '0;
            dig_r   <= '0;
            sq_r    <= 1'b1;
            dv_r    <= 1'b0;
            acc_r   <= '0;
            state_r <= ST_MAC;
          end else begin
            comp_r  <= comp_r + 1'b1;
            state_r <= ST_SUMGO;
          end
        end
        ST_SQCHK: begin
          sq_n_r   <= acc_r[NW-1:0];
          sq_res_r <= '0;
          sq_bit_r <= SQ_TOP;
          sq_cnt_r <= '0;
          state_r  <= (acc_r == '0) ? ST_OUT : ST_SQRT;
        end
        ST_SQRT: begin
          if (sq_n_r >= sq_t) begin
            sq_n_r   <= sq_n_r - sq_t;
            sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
          end else begin
            sq_res_r <= sq_res_r >> 1;
          end
          sq_bit_r <= sq_bit_r >> 2;
          sq_cnt_r <= sq_cnt_r + 1'b1;
          if (sq_cnt_r == SQW'(W - 1)) begin
            comp_r  <= '0;
            state_r <= ST_NRMGO;
          end
        end
        ST_NRMGO: begin
          state_r <= ST_NRMWT;
        end
        ST_NRMWT: begin
          if (div_sts.done) begin
            q_r[comp_r] <= qn_r[comp_r] < 0 ? sat(-quo_s) : sat(quo_s);
            if (comp_r == 2'd3) begin
              state_r <= ST_OUT;
            end else begin
              comp_r  <= comp_r + 1'b1;
              state_r <= ST_NRMGO;
            end
          end
        end
        ST_OUT: begin
          if (out_if.ready) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_if.ready   = (state_r == ST_IDLE);
  assign out_if.valid  = (state_r == ST_OUT);
  assign out_if.quat_w = q_r[0];
  assign out_if.quat_x = q_r[1];
  assign out_if.quat_y = q_r[2];
  assign out_if.quat_z = q_r[3];

  `ASSERT_CLK(a_div_start_idle, div_ctl.start |-> !div_sts.busy, "divider started while busy")
  `ASSERT_CLK(a_div_done_wait, div_sts.done |-> (state_r == ST_SUMWT || state_r == ST_NRMWT),
              "divider result with no one waiting")
  `ASSERT_NEVER(a_out_sym, out_if.valid && (out_if.quat_w == {1'b1, {(W-1){1'b0}}}),
                "result outside symmetric range")

endmodule
